FILE: design/paps_pkg.sv
// ----------------------------------------------------------------------------
// Alert pattern sequencer package
// Shared payload types, request and register codes, and the pattern tables.
// ----------------------------------------------------------------------------
package paps_pkg;

  localparam int CFG_IDX_W = 3;

  // Request types
  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_PLAY     = 3'd1;
  localparam logic [2:0] REQ_STOP_ALL = 3'd2;
  localparam logic [2:0] REQ_STOP_ONE = 3'd3;
  localparam logic [2:0] REQ_PIN      = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_AH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_AH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_AH        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_PRESENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_PRESENT   = 3'd4;

  // LED routing of a pattern
  localparam logic [1:0] ROUTE_WHITE = 2'd0;
  localparam logic [1:0] ROUTE_BLUE  = 2'd1;
  localparam logic [1:0] ROUTE_RED   = 2'd2;

  // Row of the step tables used by the device error pattern
  localparam logic [3:0] TBL_DEV_ERR = 4'd8;

  localparam logic [10:0] ELAPSED_MAX = 11'd2047;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] pattern_code;
    logic       pin_entry_flag;
  } req_t;

  typedef struct packed {
    logic        play_accepted;
    logic [3:0]  current_pattern;
    logic [11:0] tone_hz;
    logic        white_led_level;
    logic        blue_led_level;
    logic        red_led_level;
  } rsp_t;

  typedef struct packed {
    logic white_ah;
    logic blue_ah;
    logic red_ah;
    logic blue_present;
    logic red_present;
  } cfg_t;

  typedef struct packed {
    logic        buzz;
    logic        led;
    logic [10:0] dur;
  } step_t;

  typedef struct packed {
    logic [3:0]  tbl;
    logic [3:0]  count;
    logic        loops;
    logic [6:0]  prio;
    logic [11:0] tone;
    logic [1:0]  route;
  } desc_t;

  function automatic desc_t desc_lookup(input logic [3:0] code);
    desc_t d;
    d = '{4'd0, 4'd0, 1'b0, 7'd0, 12'd2800, ROUTE_WHITE};
    case (code)
      4'd1:    d = '{4'd0, 4'd2,  1'b0, 7'd10,  12'd3200, ROUTE_BLUE};
      4'd2:    d = '{4'd1, 4'd3,  1'b0, 7'd30,  12'd3200, ROUTE_WHITE};
      4'd3:    d = '{4'd2, 4'd4,  1'b0, 7'd50,  12'd2400, ROUTE_RED};
      4'd4:    d = '{4'd2, 4'd4,  1'b0, 7'd50,  12'd2400, ROUTE_RED};
      4'd5:    d = '{4'd3, 4'd6,  1'b0, 7'd60,  12'd2400, ROUTE_RED};
      4'd6:    d = '{4'd4, 4'd10, 1'b1, 7'd80,  12'd2800, ROUTE_RED};
      4'd7:    d = '{4'd5, 4'd2,  1'b1, 7'd90,  12'd4000, ROUTE_RED};
      4'd8:    d = '{4'd6, 4'd4,  1'b1, 7'd100, 12'd2800, ROUTE_RED};
      4'd9:    d = '{4'd7, 4'd2,  1'b1, 7'd20,  12'd2800, ROUTE_WHITE};
      4'd10:   d = '{TBL_DEV_ERR, 4'd4, 1'b1, 7'd70, 12'd2800, ROUTE_RED};
      default: d = '{4'd0, 4'd0, 1'b0, 7'd0, 12'd2800, ROUTE_WHITE};
    endcase
    return d;
  endfunction

  // Entries past the end of a row read as all zero; the device error row instead repeats its four entries.
  function automatic step_t step_lookup(input logic [3:0] tbl, input logic [3:0] idx);
    step_t s;
    s = '0;
    case (tbl)
      4'd0: begin
        case (idx)
          4'd0:    s = '{1'b1, 1'b1, 11'd90};
          4'd1:    s = '{1'b0, 1'b0, 11'd1};
          default: s = '0;
        endcase
      end
      4'd1: begin
        case (idx)
          4'd0:    s = '{1'b1, 1'b1, 11'd250};
          4'd1:    s = '{1'b0, 1'b1, 11'd450};
          4'd2:    s = '{1'b0, 1'b0, 11'd1};
          default: s = '0;
        endcase
      end
      4'd2: begin
        case (idx)
          4'd0:    s = '{1'b1, 1'b1, 11'd180};
          4'd1:    s = '{1'b0, 1'b0, 11'd120};
          4'd2:    s = '{1'b1, 1'b1, 11'd220};
          4'd3:    s = '{1'b0, 1'b0, 11'd1};
          default: s = '0;
        endcase
      end
      4'd3: begin
        case (idx)
          4'd0:    s = '{1'b1, 1'b1, 11'd220};
          4'd1:    s = '{1'b0, 1'b0, 11'd120};
          4'd2:    s = '{1'b1, 1'b1, 11'd220};
          4'd3:    s = '{1'b0, 1'b0, 11'd120};
          4'd4:    s = '{1'b1, 1'b1, 11'd400};
          4'd5:    s = '{1'b0, 1'b0, 11'd1};
          default: s = '0;
        endcase
      end
      4'd4: begin
        // Nine 100 ms steps alternating on and off, then a long pause.
        if (idx < 4'd9) begin
          s = '{~idx[0], ~idx[0], 11'd100};
        end else if (idx == 4'd9) begin
          s = '{1'b0, 1'b0, 11'd700};
        end
      end
      4'd5: begin
        case (idx)
          4'd0:    s = '{1'b1, 1'b1, 11'd400};
          4'd1:    s = '{1'b1, 1'b0, 11'd400};
          default: s = '0;
        endcase
      end
      4'd6: begin
        case (idx)
          4'd0:    s = '{1'b1, 1'b1, 11'd250};
          4'd1:    s = '{1'b0, 1'b0, 11'd100};
          4'd2:    s = '{1'b1, 1'b0, 11'd250};
          4'd3:    s = '{1'b0, 1'b1, 11'd100};
          default: s = '0;
        endcase
      end
      4'd7: begin
        case (idx)
          4'd0:    s = '{1'b0, 1'b1, 11'd300};
          4'd1:    s = '{1'b0, 1'b0, 11'd1700};
          default: s = '0;
        endcase
      end
      TBL_DEV_ERR: begin
        case (idx[1:0])
          2'd0:    s = '{1'b1, 1'b1, 11'd400};
          2'd1:    s = '{1'b0, 1'b0, 11'd200};
          2'd2:    s = '{1'b1, 1'b1, 11'd400};
          default: s = '{1'b0, 1'b0, 11'd800};
        endcase
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

FILE: design/paps_in_stage.sv
// ----------------------------------------------------------------------------
// Alert pattern sequencer input stage
// Holds one accepted request until the engine consumes it.
// ----------------------------------------------------------------------------
module paps_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  paps_pkg::req_t in_item,
  input  logic          take,
  output logic          held_valid,
  output paps_pkg::req_t held_item
);
  import paps_pkg::*;

  logic load;

  // The slot frees up in the same cycle that the engine takes its request.
  assign in_stall = held_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= in_item;
    end
  end

endmodule

FILE: design/paps_engine.sv
// ----------------------------------------------------------------------------
// Alert pattern sequencer engine
// Pattern state and the single-pass update for one request.
// ----------------------------------------------------------------------------
module paps_engine #(
  parameter int MAX_STEPS = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  paps_pkg::req_t item,
  input  paps_pkg::cfg_t cfg,
  output paps_pkg::rsp_t result
);
  import paps_pkg::*;

  localparam logic [4:0] MaxSteps = 5'(MAX_STEPS);

  // Pattern state
  logic [3:0]  active_code, active_code_next;
  logic [3:0]  step_index, step_index_next;
  logic [10:0] step_elapsed_ms, step_elapsed_ms_next;
  logic        pin_entry_state, pin_entry_state_next;
  // bit 0 white level, bit 1 blue level, bit 2 red level, bit 3 buzzer on
  logic [3:0]  led_drive_bits, led_drive_bits_next;

  desc_t       cur_desc, play_desc, app_desc, out_desc;
  step_t       cur_step, app_step;
  logic [4:0]  cur_limit, play_limit, next_idx;
  logic [10:0] elapsed_inc;
  logic        step_done, last_step, accepted;
  logic [3:0]  apply_code, apply_idx;
  logic [3:0]  apply_bits, finish_bits, pin_bits;

  assign cur_desc  = desc_lookup(active_code);
  assign cur_step  = step_lookup(cur_desc.tbl, step_index);
  assign play_desc = desc_lookup(item.pattern_code);

  assign cur_limit  = ({1'b0, cur_desc.count} > MaxSteps) ? MaxSteps : {1'b0, cur_desc.count};
  assign play_limit = ({1'b0, play_desc.count} > MaxSteps) ? MaxSteps : {1'b0, play_desc.count};

  assign elapsed_inc = (step_elapsed_ms != ELAPSED_MAX) ? step_elapsed_ms + 11'd1
                                                        : step_elapsed_ms;
  assign step_done   = elapsed_inc >= cur_step.dur;
  assign next_idx    = {1'b0, step_index} + 5'd1;
  assign last_step   = next_idx >= cur_limit;

  // The step to show next: step 0 of a new pattern, or the following step
  // (wrapping to step 0) of the running one.
  assign apply_code = (item.req_type == REQ_PLAY) ? item.pattern_code : active_code;
  assign apply_idx  = ((item.req_type == REQ_PLAY) || last_step) ? 4'd0 : next_idx[3:0];
  assign app_desc   = desc_lookup(apply_code);
  assign app_step   = step_lookup(app_desc.tbl, apply_idx);

  // Absent LEDs keep whatever level was last written.
  assign apply_bits[0] = ((app_desc.route == ROUTE_WHITE) && app_step.led) ~^ cfg.white_ah;
  assign apply_bits[1] = cfg.blue_present
                         ? (((app_desc.route == ROUTE_BLUE) && app_step.led) ~^ cfg.blue_ah)
                         : led_drive_bits[1];
  assign apply_bits[2] = cfg.red_present
                         ? (((app_desc.route == ROUTE_RED) && app_step.led) ~^ cfg.red_ah)
                         : led_drive_bits[2];
  assign apply_bits[3] = app_step.buzz;

  // Idle look: everything dark and silent, blue showing the pin-entry flag.
  assign finish_bits[0] = ~cfg.white_ah;
  assign finish_bits[1] = cfg.blue_present ? (pin_entry_state ~^ cfg.blue_ah)
                                           : led_drive_bits[1];
  assign finish_bits[2] = cfg.red_present ? ~cfg.red_ah : led_drive_bits[2];
  assign finish_bits[3] = 1'b0;

  assign pin_bits[0] = ~cfg.white_ah;
  assign pin_bits[1] = cfg.blue_present ? (item.pin_entry_flag ~^ cfg.blue_ah)
                                        : led_drive_bits[1];
  assign pin_bits[2] = cfg.red_present ? ~cfg.red_ah : led_drive_bits[2];
  assign pin_bits[3] = led_drive_bits[3];

  always_comb begin
    active_code_next     = active_code;
    step_index_next      = step_index;
    step_elapsed_ms_next = step_elapsed_ms;
    pin_entry_state_next = pin_entry_state;
    led_drive_bits_next  = led_drive_bits;
    accepted             = 1'b0;
    unique case (item.req_type)
      REQ_TICK: begin
        if (active_code != 4'd0) begin
          if (!step_done) begin
            step_elapsed_ms_next = elapsed_inc;
          end else begin
            step_elapsed_ms_next = '0;
            if (last_step && !cur_desc.loops) begin
              active_code_next    = '0;
              step_index_next     = '0;
              led_drive_bits_next = finish_bits;
            end else begin
              step_index_next     = apply_idx;
              led_drive_bits_next = apply_bits;
            end
          end
        end
      end
      REQ_PLAY: begin
        if (item.pattern_code == 4'd0) begin
          accepted = 1'b0;
        end else if (active_code == item.pattern_code) begin
          accepted = 1'b1;
        end else if (active_code != 4'd0 && play_desc.prio < cur_desc.prio) begin
          accepted = 1'b0;
        end else if (play_limit == 5'd0) begin
          accepted = 1'b0;
        end else begin
          active_code_next     = item.pattern_code;
          step_index_next      = '0;
          step_elapsed_ms_next = '0;
          led_drive_bits_next  = apply_bits;
          accepted             = 1'b1;
        end
      end
      REQ_STOP_ALL: begin
        active_code_next     = '0;
        step_index_next      = '0;
        step_elapsed_ms_next = '0;
        led_drive_bits_next  = finish_bits;
      end
      REQ_STOP_ONE: begin
        if (active_code == item.pattern_code) begin
          active_code_next     = '0;
          step_index_next      = '0;
          step_elapsed_ms_next = '0;
          led_drive_bits_next  = finish_bits;
        end
      end
      REQ_PIN: begin
        pin_entry_state_next = item.pin_entry_flag;
        if (active_code == 4'd0) begin
          led_drive_bits_next = pin_bits;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_desc = desc_lookup(active_code_next);

  always_comb begin
    result.play_accepted   = accepted;
    result.current_pattern = active_code_next;
    result.tone_hz         = led_drive_bits_next[3] ? out_desc.tone : 12'd0;
    result.white_led_level = led_drive_bits_next[0];
    result.blue_led_level  = led_drive_bits_next[1];
    result.red_led_level   = led_drive_bits_next[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_code     <= '0;
      step_index      <= '0;
      step_elapsed_ms <= '0;
      pin_entry_state <= 1'b0;
      led_drive_bits  <= '0;
    end else if (fire) begin
      active_code     <= active_code_next;
      step_index      <= step_index_next;
      step_elapsed_ms <= step_elapsed_ms_next;
      pin_entry_state <= pin_entry_state_next;
      led_drive_bits  <= led_drive_bits_next;
    end
  end

endmodule

FILE: design/paps_out_stage.sv
// ----------------------------------------------------------------------------
// Alert pattern sequencer output stage
// Result register that holds a transaction while the consumer stalls.
// ----------------------------------------------------------------------------
module paps_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  paps_pkg::rsp_t result_in,
  output logic           ready,
  output logic           out_valid,
  input  logic           out_stall,
  output paps_pkg::rsp_t out_result
);
  import paps_pkg::*;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= result_in;
    end
  end

endmodule

FILE: design/priority_alert_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// Priority alert pattern sequencer
// Plays prioritized buzzer and LED alert patterns, one request per transaction.
// ----------------------------------------------------------------------------
//   Channel  Handshake             Payload     Direction
//   in       in_valid / in_stall   in_item     request in
//   out      out_valid / out_stall out_result  result out
//   cfg      cfg_we                cfg_index,  register write
//                                  cfg_data
//
// One request per cycle is sustained while out_stall stays low; a result turns
// valid after its request passes the input register, then the result register.
// The whole update is a set of table lookups and a counter step in the engine.
// Reset is synchronous and needs no clearing time.
// A stalled result holds the result register; the input register then fills
// and in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module priority_alert_pattern_sequencer #(
  parameter int MAX_STEPS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  paps_pkg::req_t                 in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output paps_pkg::rsp_t                 out_result,
  input  logic                           cfg_we,
  input  logic [paps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data
);
  import paps_pkg::*;

  cfg_t cfg;
  req_t held_item;
  rsp_t result;
  logic held_valid;
  logic out_ready;
  logic take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHITE_AH:     cfg.white_ah     <= cfg_data;
        CFG_BLUE_AH:      cfg.blue_ah      <= cfg_data;
        CFG_RED_AH:       cfg.red_ah       <= cfg_data;
        CFG_BLUE_PRESENT: cfg.blue_present <= cfg_data;
        CFG_RED_PRESENT:  cfg.red_present  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign take = held_valid && out_ready;

  paps_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  paps_engine #(
    .MAX_STEPS (MAX_STEPS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (take),
    .item   (held_item),
    .cfg    (cfg),
    .result (result)
  );

  paps_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .result_in  (result),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  // A request taken by the engine always shows up as a result next cycle.
  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("engine consumed a request but no result was registered");

  // A held request is never dropped while the result side is blocked.
  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    held_valid && !take |=> held_valid)
    else $error("held request lost while stalled");

  // An idle sequencer is silent.
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.current_pattern == 4'd0 |-> out_result.tone_hz == 12'd0)
    else $error("tone reported with no active pattern");

  // Only the four pattern tones can sound.
  a_tone_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.tone_hz != 12'd0 |->
      out_result.tone_hz == 12'd2400 || out_result.tone_hz == 12'd2800 ||
      out_result.tone_hz == 12'd3200 || out_result.tone_hz == 12'd4000)
    else $error("illegal buzzer tone");

endmodule
